// ===== hdl/rgb_sharpen_luma_histogram_macros.svh =====
// Assertion macros for the RGB sharpener with luminance histogram.
// Included by the top level; depends on nothing else.
`ifndef RGB_SHARPEN_LUMA_HISTOGRAM_MACROS_SVH
`define RGB_SHARPEN_LUMA_HISTOGRAM_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RGBSLH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define RGBSLH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/rgbslh_pkg.sv =====
// Package for the RGB sharpener with luminance histogram: types, codes, constants
// and the per-pixel arithmetic functions. Depends on nothing.
package rgbslh_pkg;

   // Default values of the top-level parameters.
   localparam int unsigned MAX_WIDTH_DEF  = 1024;
   localparam int unsigned COUNT_BITS_DEF = 32;

   // Configuration port and register widths.
   localparam int unsigned CSR_IDX_BITS    = 2;
   localparam int unsigned CSR_DATA_BITS   = 16;
   localparam int unsigned CFG_WIDTH_BITS  = 11;
   localparam int unsigned CFG_HEIGHT_BITS = 16;
   localparam int unsigned WIDTH_RESET     = 640;
   localparam int unsigned HEIGHT_RESET    = 480;

   // Transaction field widths.
   localparam int unsigned CHAN_BITS      = 8;
   localparam int unsigned CMD_BITS       = 2;
   localparam int unsigned BIN_BITS       = 3;
   localparam int unsigned NUM_BINS       = 5;
   localparam int unsigned COUNT_OUT_BITS = 32;

   // BT.709 luma weights scaled by 2^16, with a rounding offset.
   localparam int unsigned LUMA_W_RED     = 13933;
   localparam int unsigned LUMA_W_GREEN   = 46871;
   localparam int unsigned LUMA_W_BLUE    = 4732;
   localparam int unsigned LUMA_ROUND     = 32768;
   localparam int unsigned LUMA_SHIFT     = 16;
   localparam int unsigned LUMA_ACC_BITS  = 25;

   // Upper luma limits of bins zero to three; anything above falls in bin four.
   localparam int unsigned LUMA_LIMIT_0 = 50;
   localparam int unsigned LUMA_LIMIT_1 = 101;
   localparam int unsigned LUMA_LIMIT_2 = 152;
   localparam int unsigned LUMA_LIMIT_3 = 203;

   // Sharpening kernel: centre weight and output ceiling.
   localparam int unsigned CENTRE_WEIGHT = 5;
   localparam int unsigned CHAN_MAX      = 255;
   localparam int unsigned SUM_BITS      = 12;

   // Result kinds.
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_COUNT = 1'b1;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_PIXEL    = 2'd0,
      CMD_DRAIN    = 2'd1,
      CMD_READ_BIN = 2'd2,
      CMD_START    = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1
   } csr_index_type;

   // Work that travels down the back end of the pipeline.
   typedef enum logic [1:0] {
      OP_PIXEL,
      OP_COUNT,
      OP_CLEAR
   } op_type;

   typedef logic [CHAN_BITS-1:0] chan_type;

   typedef struct packed {
      chan_type red;
      chan_type green;
      chan_type blue;
   } rgb_type;

   typedef struct packed {
      op_type                op;
      rgb_type               pix;
      logic                  frame_end;
      logic [BIN_BITS-1:0]   sel;
   } stage_type;

   // One channel of 5*centre - left - right - up - down, clamped to 0..255.
   function automatic chan_type sharpen_chan(input chan_type c, input chan_type l,
                                             input chan_type r, input chan_type u,
                                             input chan_type d);
      logic [SUM_BITS-1:0] pos;
      logic [SUM_BITS-1:0] neg;
      logic [SUM_BITS-1:0] diff;
      pos  = SUM_BITS'(CENTRE_WEIGHT) * SUM_BITS'(c);
      neg  = SUM_BITS'(l) + SUM_BITS'(r) + SUM_BITS'(u) + SUM_BITS'(d);
      diff = pos - neg;
      if (pos < neg) begin
         return '0;
      end
      if (diff > SUM_BITS'(CHAN_MAX)) begin
         return CHAN_BITS'(CHAN_MAX);
      end
      return diff[CHAN_BITS-1:0];
   endfunction

   // Rounded fixed-point luma of a pixel, sorted into one of the five bins.
   function automatic logic [BIN_BITS-1:0] luma_bin(input rgb_type p);
      logic [LUMA_ACC_BITS-1:0] acc;
      chan_type                 luma;
      acc  = LUMA_ACC_BITS'(LUMA_W_RED * 32'(p.red))
           + LUMA_ACC_BITS'(LUMA_W_GREEN * 32'(p.green))
           + LUMA_ACC_BITS'(LUMA_W_BLUE * 32'(p.blue))
           + LUMA_ACC_BITS'(LUMA_ROUND);
      luma = CHAN_BITS'(acc >> LUMA_SHIFT);
      if (luma <= CHAN_BITS'(LUMA_LIMIT_0)) begin
         return BIN_BITS'(0);
      end
      if (luma <= CHAN_BITS'(LUMA_LIMIT_1)) begin
         return BIN_BITS'(1);
      end
      if (luma <= CHAN_BITS'(LUMA_LIMIT_2)) begin
         return BIN_BITS'(2);
      end
      if (luma <= CHAN_BITS'(LUMA_LIMIT_3)) begin
         return BIN_BITS'(3);
      end
      return BIN_BITS'(4);
   endfunction

endpackage

// ===== hdl/rgb_sharpen_luma_histogram.sv =====
// Top level of the RGB 5-point Laplacian sharpener with luminance histogram.
// Depends on rgbslh_pkg and on rgb_sharpen_luma_histogram_macros.svh.
//
// The block takes one transaction per clock and sustains that rate as long as
// the result side keeps taking results; once its transaction is accepted, a result
// is registered in the front end, the luma stage and the output register. Pixels
// come out one image row behind the input, and the last row is pulled out with
// drain commands. Two line buffers of MAX_WIDTH x 24 bits hold the two previous
// rows; each is a simple dual-port memory doing one read and one write per pixel,
// which is what sets the one-pixel-per-clock figure: the centre and right
// neighbors are prefetched one column ahead, the left neighbor is kept in a
// register, and the first two entries of the middle row are mirrored in
// registers so a new row starts without a memory read. The line buffers need
// no clearing pass after reset. Histogram counters saturate at 2^COUNT_BITS - 1,
// are read back with the read-bin command and are cleared by start frame.
`include "rgb_sharpen_luma_histogram_macros.svh"

module rgb_sharpen_luma_histogram #(
   parameter int unsigned MAX_WIDTH  = rgbslh_pkg::MAX_WIDTH_DEF,
   parameter int unsigned COUNT_BITS = rgbslh_pkg::COUNT_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Input transactions.
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic [rgbslh_pkg::CMD_BITS-1:0]          req_cmd,
   input  logic [rgbslh_pkg::CHAN_BITS-1:0]         req_in_red,
   input  logic [rgbslh_pkg::CHAN_BITS-1:0]         req_in_green,
   input  logic [rgbslh_pkg::CHAN_BITS-1:0]         req_in_blue,
   input  logic [rgbslh_pkg::BIN_BITS-1:0]          req_bin_index,
   // Result transactions.
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic                                     rsp_kind,
   output logic [rgbslh_pkg::CHAN_BITS-1:0]         rsp_out_red,
   output logic [rgbslh_pkg::CHAN_BITS-1:0]         rsp_out_green,
   output logic [rgbslh_pkg::CHAN_BITS-1:0]         rsp_out_blue,
   output logic [rgbslh_pkg::COUNT_OUT_BITS-1:0]    rsp_bin_count,
   output logic                                     rsp_frame_end,
   // Configuration writes.
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [rgbslh_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [rgbslh_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import rgbslh_pkg::*;

   localparam int unsigned COL_BITS  = $clog2(MAX_WIDTH);
   localparam int unsigned W_BITS    = $clog2(MAX_WIDTH + 1);
   localparam int unsigned ROW_BITS  = CFG_HEIGHT_BITS;
   localparam int unsigned CNT_BITS  = W_BITS + ROW_BITS;
   localparam int unsigned ADDR_BITS = COL_BITS + 2;
   localparam int unsigned WIDTH_RESET_EFF =
      (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
   localparam int unsigned TOTAL_RESET = WIDTH_RESET_EFF * HEIGHT_RESET;

   // Effective width: zero acts as one, anything above the buffer depth is clipped.
   function automatic logic [W_BITS-1:0] eff_width(input logic [CFG_WIDTH_BITS-1:0] v);
      if (v == '0) begin
         return W_BITS'(1);
      end
      if (32'(v) > MAX_WIDTH) begin
         return W_BITS'(MAX_WIDTH);
      end
      return W_BITS'(v);
   endfunction

   // Effective height: zero acts as one.
   function automatic logic [ROW_BITS-1:0] eff_height(input logic [ROW_BITS-1:0] v);
      return (v == '0) ? ROW_BITS'(1) : v;
   endfunction

   // Line buffers.
   rgb_type row_above_mem  [MAX_WIDTH];
   rgb_type row_middle_mem [MAX_WIDTH];

   // Configuration, stored as effective values together with the frame size.
   logic [W_BITS-1:0]    weff_ff, weff_in;
   logic [ROW_BITS-1:0]  heff_ff, heff_in;
   logic [CNT_BITS-1:0]  total_ff, total_in;

   // Raster position and window state.
   logic [COL_BITS-1:0]  col_ff, col_in;
   logic [ROW_BITS-1:0]  row_ff, row_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 start_ff, start_in;
   rgb_type              cen_ff, cen_in;
   rgb_type              lft_ff, lft_in;
   rgb_type              d0_ff, d0_in;
   rgb_type              d1_ff, d1_in;
   rgb_type              mid_rd_ff;
   rgb_type              abv_rd_ff;

   // Back-end pipeline.
   logic                 s1_valid_ff, s1_valid_in;
   stage_type            s1_ff, s1_in;
   logic                 s2_valid_ff, s2_valid_in;
   stage_type            s2_ff, s2_in;
   logic [BIN_BITS-1:0]  s2_bin_ff, s2_bin_in;
   logic [NUM_BINS-1:0][COUNT_BITS-1:0] bins_ff, bins_in;

   // Output register.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_kind_ff, rsp_kind_in;
   rgb_type                    rsp_pix_ff, rsp_pix_in;
   logic [COUNT_OUT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic                       rsp_frame_end_ff, rsp_frame_end_in;

   // Front-end combinational signals.
   logic                 accept;
   logic                 clamp;
   logic                 win_start;
   logic [COL_BITS-1:0]  col_cur;
   logic [W_BITS-1:0]    col_inc;
   logic                 wrap;
   logic                 drain_ok;
   logic                 frame_last;
   logic                 border;
   rgb_type              cen_cur;
   rgb_type              rgt_cur;
   rgb_type              down_pix;
   rgb_type              sharp;
   logic                 step;
   logic                 mem_wr;
   logic                 enter;
   stage_type            entry;
   logic [ADDR_BITS-1:0] mid_addr_w;
   logic [ADDR_BITS-1:0] abv_addr_w;
   logic [COL_BITS-1:0]  mid_addr;
   logic [COL_BITS-1:0]  abv_addr;
   logic                 out_free;
   logic                 s2_free;
   logic                 s1_free;

   assign csr_ready = 1'b1;

   // Configuration writes; the frame size is recomputed with the new value.
   always_comb begin
      weff_in  = weff_ff;
      heff_in  = heff_ff;
      total_in = total_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               weff_in  = eff_width(csr_data[CFG_WIDTH_BITS-1:0]);
               total_in = CNT_BITS'(CNT_BITS'(weff_in) * CNT_BITS'(heff_ff));
            end
            CSR_IMAGE_HEIGHT: begin
               heff_in  = eff_height(csr_data[CFG_HEIGHT_BITS-1:0]);
               total_in = CNT_BITS'(CNT_BITS'(weff_ff) * CNT_BITS'(heff_in));
            end
            default: begin
            end
         endcase
      end
   end

   // Handshake chain: each stage moves when the one after it is empty or moving.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s2_free   = !s2_valid_ff || out_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free;
   assign accept    = req_valid && req_ready;

   // Window of neighbors around the current column.
   always_comb begin
      clamp      = W_BITS'(col_ff) >= weff_ff;
      col_cur    = clamp ? '0 : col_ff;
      win_start  = clamp || start_ff;
      cen_cur    = win_start ? d0_ff : cen_ff;
      rgt_cur    = win_start ? d1_ff : mid_rd_ff;
      down_pix   = {req_in_red, req_in_green, req_in_blue};
      col_inc    = W_BITS'(col_cur) + W_BITS'(1);
      wrap       = col_inc >= weff_ff;
      drain_ok   = (row_ff == heff_ff) && (cnt_ff < total_ff);
      frame_last = (cnt_ff + CNT_BITS'(1)) == total_ff;
      border     = (row_ff == ROW_BITS'(1)) || (col_cur == '0) || wrap;
      sharp.red   = sharpen_chan(cen_cur.red, lft_ff.red, rgt_cur.red,
                                 abv_rd_ff.red, down_pix.red);
      sharp.green = sharpen_chan(cen_cur.green, lft_ff.green, rgt_cur.green,
                                 abv_rd_ff.green, down_pix.green);
      sharp.blue  = sharpen_chan(cen_cur.blue, lft_ff.blue, rgt_cur.blue,
                                 abv_rd_ff.blue, down_pix.blue);
      if (border) begin
         sharp = cen_cur;
      end
      // Prefetch addresses: middle row two columns ahead, row above one ahead.
      mid_addr_w = ADDR_BITS'(col_cur) + ADDR_BITS'(2);
      abv_addr_w = ADDR_BITS'(col_cur) + ADDR_BITS'(1);
      mid_addr   = (32'(mid_addr_w) >= MAX_WIDTH) ? '0 : COL_BITS'(mid_addr_w);
      abv_addr   = (32'(abv_addr_w) >= MAX_WIDTH) ? '0 : COL_BITS'(abv_addr_w);
   end

   // Command decode and next raster state.
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      cnt_in   = cnt_ff;
      start_in = start_ff;
      cen_in   = cen_ff;
      lft_in   = lft_ff;
      d0_in    = d0_ff;
      d1_in    = d1_ff;
      step     = 1'b0;
      mem_wr   = 1'b0;
      enter    = 1'b0;
      entry.op        = OP_PIXEL;
      entry.pix       = sharp;
      entry.frame_end = frame_last;
      entry.sel       = req_bin_index;
      if (accept) begin
         col_in   = col_cur;
         start_in = win_start;
         case (cmd_type'(req_cmd))
            CMD_START: begin
               col_in   = '0;
               row_in   = '0;
               cnt_in   = '0;
               start_in = 1'b1;
               enter    = 1'b1;
               entry.op = OP_CLEAR;
            end
            CMD_READ_BIN: begin
               enter    = 1'b1;
               entry.op = OP_COUNT;
            end
            CMD_DRAIN: begin
               if (drain_ok) begin
                  step      = 1'b1;
                  enter     = 1'b1;
                  entry.pix = cen_cur;
                  cnt_in    = cnt_ff + CNT_BITS'(1);
               end
            end
            CMD_PIXEL: begin
               if (row_ff < heff_ff) begin
                  step   = 1'b1;
                  mem_wr = 1'b1;
                  if (row_ff != '0) begin
                     enter  = 1'b1;
                     cnt_in = cnt_ff + CNT_BITS'(1);
                  end
                  if (col_cur == COL_BITS'(0)) begin
                     d0_in = down_pix;
                  end
                  if (col_cur == COL_BITS'(1)) begin
                     d1_in = down_pix;
                  end
               end
            end
            default: begin
            end
         endcase
         // Slide the window one column; a new row restarts from the mirrored entries.
         if (step) begin
            cen_in   = rgt_cur;
            lft_in   = cen_cur;
            start_in = wrap;
            col_in   = wrap ? '0 : COL_BITS'(col_inc);
            if (wrap && mem_wr) begin
               row_in = row_ff + ROW_BITS'(1);
            end
         end
      end
   end

   // Back end: luma binning, histogram update and the output register.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (s1_free) begin
         s1_valid_in = accept && enter;
         s1_in       = entry;
      end
      s2_valid_in = s2_valid_ff;
      s2_in       = s2_ff;
      s2_bin_in   = s2_bin_ff;
      if (s2_free) begin
         s2_valid_in = s1_valid_ff;
         s2_in       = s1_ff;
         s2_bin_in   = luma_bin(s1_ff.pix);
      end
      bins_in          = bins_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_kind_in      = rsp_kind_ff;
      rsp_pix_in       = rsp_pix_ff;
      rsp_count_in     = rsp_count_ff;
      rsp_frame_end_in = rsp_frame_end_ff;
      if (out_free) begin
         rsp_valid_in     = s2_valid_ff && (s2_ff.op != OP_CLEAR);
         rsp_kind_in      = KIND_PIXEL;
         rsp_pix_in       = s2_ff.pix;
         rsp_count_in     = '0;
         rsp_frame_end_in = s2_ff.frame_end;
         if (s2_valid_ff) begin
            case (s2_ff.op)
               OP_PIXEL: begin
                  if (bins_ff[s2_bin_ff] != '1) begin
                     bins_in[s2_bin_ff] = bins_ff[s2_bin_ff] + COUNT_BITS'(1);
                  end
               end
               OP_COUNT: begin
                  rsp_kind_in      = KIND_COUNT;
                  rsp_pix_in       = '0;
                  rsp_frame_end_in = 1'b0;
                  if (32'(s2_ff.sel) < NUM_BINS) begin
                     rsp_count_in = COUNT_OUT_BITS'(bins_ff[s2_ff.sel]);
                  end
               end
               OP_CLEAR: begin
                  bins_in = '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         weff_ff      <= W_BITS'(WIDTH_RESET_EFF);
         heff_ff      <= ROW_BITS'(HEIGHT_RESET);
         total_ff     <= CNT_BITS'(TOTAL_RESET);
         col_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         start_ff     <= 1'b1;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         bins_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         weff_ff      <= weff_in;
         heff_ff      <= heff_in;
         total_ff     <= total_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         start_ff     <= start_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         bins_ff      <= bins_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cen_ff           <= cen_in;
      lft_ff           <= lft_in;
      d0_ff            <= d0_in;
      d1_ff            <= d1_in;
      s1_ff            <= s1_in;
      s2_ff            <= s2_in;
      s2_bin_ff        <= s2_bin_in;
      rsp_kind_ff      <= rsp_kind_in;
      rsp_pix_ff       <= rsp_pix_in;
      rsp_count_ff     <= rsp_count_in;
      rsp_frame_end_ff <= rsp_frame_end_in;
   end

   // Line buffers: write the current column, prefetch the columns ahead.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         row_above_mem[col_cur]  <= cen_cur;
         row_middle_mem[col_cur] <= down_pix;
      end
      if (step) begin
         mid_rd_ff <= row_middle_mem[mid_addr];
         abv_rd_ff <= row_above_mem[abv_addr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_out_red   = rsp_pix_ff.red;
   assign rsp_out_green = rsp_pix_ff.green;
   assign rsp_out_blue  = rsp_pix_ff.blue;
   assign rsp_bin_count = rsp_count_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // A stalled first stage keeps its transaction.
   `RGBSLH_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s2_free, s1_valid_ff && $stable(s1_ff), "s1 transaction lost while stalled")
   // The frame-end pixel brings the emitted count up to the frame size.
   `RGBSLH_ASSERT_NEXT(a_frame_end_count, clock, reset, accept && enter && entry.op == OP_PIXEL && entry.frame_end && !csr_valid, cnt_ff == total_ff, "frame end flagged before the frame size was reached")
   // Start frame leaves every histogram bin at zero.
   `RGBSLH_ASSERT_NEXT(a_bins_cleared, clock, reset, s2_valid_ff && s2_ff.op == OP_CLEAR && out_free, bins_ff == '0, "histogram bins not cleared at frame start")

endmodule

// ===== tb/sv/tb_rgb_sharpen_luma_histogram.sv =====
// Self-checking testbench for the RGB 5-point sharpener with luminance histogram.
// Depends on rgbslh_pkg and the top level rgb_sharpen_luma_histogram.
`timescale 1ns / 100ps

module tb_rgb_sharpen_luma_histogram;
   import rgbslh_pkg::*;

   localparam int unsigned LINE_DEPTH   = MAX_WIDTH_DEF;
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned SETTLE_DELAY = 8;
   localparam int unsigned REPORT_CAP   = 100;
   localparam int unsigned RANDOM_ITEMS = 1400;

   // BT.709 weights scaled by 2^16 and the upper luma limit of each bin.
   localparam int unsigned WEIGHT_RED   = 13933;
   localparam int unsigned WEIGHT_GREEN = 46871;
   localparam int unsigned WEIGHT_BLUE  = 4732;
   localparam int unsigned HALF_LSB     = 32768;
   localparam int unsigned HIST_BINS    = 5;
   localparam int unsigned BIN_LIMIT [4] = '{50, 101, 152, 203};

   typedef struct packed {
      logic        kind;
      rgb_type     pix;
      logic [31:0] count;
      logic        frame_end;
   } result_word;

   logic                      clock;
   logic                      reset         = 1'b1;
   logic                      req_valid     = 1'b0;
   logic                      req_ready;
   logic [CMD_BITS-1:0]       req_cmd       = '0;
   logic [CHAN_BITS-1:0]      req_in_red    = '0;
   logic [CHAN_BITS-1:0]      req_in_green  = '0;
   logic [CHAN_BITS-1:0]      req_in_blue   = '0;
   logic [BIN_BITS-1:0]       req_bin_index = '0;
   logic                      rsp_valid;
   logic                      rsp_ready     = 1'b0;
   logic                      rsp_kind;
   logic [CHAN_BITS-1:0]      rsp_out_red;
   logic [CHAN_BITS-1:0]      rsp_out_green;
   logic [CHAN_BITS-1:0]      rsp_out_blue;
   logic [COUNT_OUT_BITS-1:0] rsp_bin_count;
   logic                      rsp_frame_end;
   logic                      csr_valid     = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_BITS-1:0]   csr_index     = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data      = '0;

   // Shadow of the block: registers, line buffers, position and histogram.
   logic [10:0]     width_reg  = 11'd640;
   logic [15:0]     height_reg = 16'd480;
   rgb_type         line_above  [LINE_DEPTH];
   rgb_type         line_middle [LINE_DEPTH];
   int unsigned     col_now     = 0;
   int unsigned     row_now     = 0;
   longint unsigned pix_emitted = 0;
   logic [31:0]     bin_tally [HIST_BINS];

   result_word  expected_q [$];
   int unsigned error_count  = 0;
   int unsigned items_sent   = 0;
   int unsigned quiet_cycles = 0;
   bit          steady       = 1'b0;

   rgb_sharpen_luma_histogram #(
      .MAX_WIDTH  (LINE_DEPTH),
      .COUNT_BITS (32)
   ) DUT (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Effective frame size as the block sees it.
   function automatic int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
   endfunction

   function automatic int unsigned active_height();
      return (height_reg == 0) ? 1 : height_reg;
   endfunction

   // One channel of 5*centre minus the four neighbors, clamped to 0..255.
   function automatic chan_type sharpen_channel(input chan_type c, input chan_type l,
                                                input chan_type r, input chan_type u,
                                                input chan_type d);
      int acc;
      acc = 5 * int'(c) - int'(l) - int'(r) - int'(u) - int'(d);
      if (acc > 255) acc = 255;
      if (acc < 0) acc = 0;
      return chan_type'(acc);
   endfunction

   function automatic int unsigned luma_bin_of(input rgb_type p);
      int unsigned luma;
      luma = (WEIGHT_RED * int'(p.red) + WEIGHT_GREEN * int'(p.green)
              + WEIGHT_BLUE * int'(p.blue) + HALF_LSB) >> 16;
      for (int i = 0; i < 4; i++) begin
         if (luma <= BIN_LIMIT[i]) return i;
      end
      return 4;
   endfunction

   // An emitted pixel is expected on the result side and lands in a luma bin.
   function automatic void emit_pixel(input rgb_type p);
      result_word      r;
      int unsigned     b;
      longint unsigned total;
      b     = luma_bin_of(p);
      total = longint'(active_width()) * active_height();
      if (bin_tally[b] != 32'hFFFF_FFFF) bin_tally[b]++;
      r           = '0;
      r.kind      = KIND_PIXEL;
      r.pix       = p;
      r.frame_end = (pix_emitted + 1 == total);
      expected_q.push_back(r);
      pix_emitted++;
   endfunction

   function automatic void advance_column(input int unsigned w, input bit next_row);
      col_now++;
      if (col_now >= w) begin
         col_now = 0;
         if (next_row) row_now++;
      end
   endfunction

   // Updates the shadow state for one accepted transaction.
   function automatic void predict_item(input cmd_type cmd, input rgb_type pix,
                                        input logic [BIN_BITS-1:0] bin);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      rgb_type     centre;
      rgb_type     left;
      rgb_type     right;
      rgb_type     up;
      rgb_type     res;
      result_word  r;
      w = active_width();
      h = active_height();
      if (col_now >= w) col_now = 0;
      c = col_now;
      case (cmd)
         CMD_START: begin
            col_now     = 0;
            row_now     = 0;
            pix_emitted = 0;
            foreach (bin_tally[i]) bin_tally[i] = '0;
         end
         CMD_READ_BIN: begin
            r       = '0;
            r.kind  = KIND_COUNT;
            r.count = (bin < HIST_BINS) ? bin_tally[bin] : 32'd0;
            expected_q.push_back(r);
         end
         CMD_DRAIN: begin
            // Only once every row is in and the frame is not yet complete.
            if (row_now == h && pix_emitted < longint'(w) * h) begin
               emit_pixel(line_middle[c]);
               advance_column(w, 1'b0);
            end
         end
         CMD_PIXEL: begin
            if (row_now < h) begin
               centre = line_middle[c];
               if (row_now >= 1) begin
                  // The bottom row leaves through drains, so only the top row and
                  // the side columns are passed through here.
                  if (row_now == 1 || c == 0 || c + 1 >= w) begin
                     res = centre;
                  end else begin
                     left      = line_above[c - 1];
                     right     = line_middle[c + 1];
                     up        = line_above[c];
                     res.red   = sharpen_channel(centre.red, left.red, right.red,
                                                 up.red, pix.red);
                     res.green = sharpen_channel(centre.green, left.green, right.green,
                                                 up.green, pix.green);
                     res.blue  = sharpen_channel(centre.blue, left.blue, right.blue,
                                                 up.blue, pix.blue);
                  end
                  emit_pixel(res);
               end
               line_above[c]  = centre;
               line_middle[c] = pix;
               advance_column(w, 1'b1);
            end
         end
         default: begin
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      if (error_count <= REPORT_CAP) begin
         $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      end
   endtask

   // Compares one accepted result with the oldest expectation.
   task automatic check_result();
      result_word want;
      if (expected_q.size() == 0) begin
         report_mismatch("result with nothing expected", rsp_kind, '0);
         return;
      end
      want = expected_q.pop_front();
      if (rsp_kind !== want.kind) report_mismatch("kind", rsp_kind, want.kind);
      if (rsp_out_red !== want.pix.red) report_mismatch("out_red", rsp_out_red, want.pix.red);
      if (rsp_out_green !== want.pix.green) begin
         report_mismatch("out_green", rsp_out_green, want.pix.green);
      end
      if (rsp_out_blue !== want.pix.blue) begin
         report_mismatch("out_blue", rsp_out_blue, want.pix.blue);
      end
      if (rsp_bin_count !== want.count) report_mismatch("bin_count", rsp_bin_count, want.count);
      if (rsp_frame_end !== want.frame_end) begin
         report_mismatch("frame_end", rsp_frame_end, want.frame_end);
      end
   endtask

   // Result side: random back pressure, and a check of every transaction taken.
   always @(posedge clock) begin
      if (!reset) begin
         rsp_ready <= steady || ($urandom_range(99) >= 13);
         if (rsp_valid && rsp_ready) check_result();
      end
   end

   // Watchdog on cycles in which no channel moves a transaction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Sends one transaction, sometimes after a random gap, and predicts it.
   task automatic send_item(input cmd_type cmd, input rgb_type pix,
                            input logic [BIN_BITS-1:0] bin);
      if (!steady && $urandom_range(99) < 13) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= cmd;
      req_in_red    <= pix.red;
      req_in_green  <= pix.green;
      req_in_blue   <= pix.blue;
      req_bin_index <= bin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(cmd, pix, bin);
      items_sent++;
   endtask

   function automatic rgb_type random_pixel();
      rgb_type p;
      case ($urandom_range(9))
         0: p = '0;
         1: p = '1;
         2: p = {{8{1'($urandom)}}, {8{1'($urandom)}}, {8{1'($urandom)}}};
         default: p = rgb_type'($urandom);
      endcase
      return p;
   endfunction

   task automatic send_pixel();
      send_item(CMD_PIXEL, random_pixel(), BIN_BITS'($urandom));
   endtask

   task automatic send_drain();
      send_item(CMD_DRAIN, random_pixel(), BIN_BITS'($urandom));
   endtask

   task automatic read_bin(input int unsigned idx);
      send_item(CMD_READ_BIN, random_pixel(), BIN_BITS'(idx));
   endtask

   // Stops sending until every expected result is back and the pipe is empty.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_DELAY) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_IMAGE_WIDTH) width_reg = data[10:0];
      else height_reg = data;
   endtask

   // Reprograms the frame size while idle and opens a new frame.
   task automatic set_frame_size(input logic [CSR_DATA_BITS-1:0] w,
                                 input logic [CSR_DATA_BITS-1:0] h);
      wait_drained();
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      csr_valid <= 1'b0;
      send_item(CMD_START, random_pixel(), BIN_BITS'($urandom));
   endtask

   // Reset sizes: empty bins, an early drain, then a row and a bit at 640 wide.
   task automatic test_reset_defaults();
      for (int i = 0; i < HIST_BINS; i++) read_bin(i);
      send_drain();
      repeat (642) send_pixel();
   endtask

   // A 3x3 frame whose centre clamps high, clamps low and lands mid-range.
   task automatic test_kernel_3x3();
      rgb_type grid [9] = '{24'h0A141E, 24'h00FF01, 24'h28323C,
                            24'h00FF02, 24'hFF0020, 24'h00FF03,
                            24'h010203, 24'h00FF04, 24'hC86432};
      set_frame_size(3, 3);
      foreach (grid[i]) send_item(CMD_PIXEL, grid[i], '0);
      repeat (4) send_drain();
      send_pixel();
      for (int i = 0; i < 8; i++) read_bin(i);
   endtask

   // A zero size acts as one; a single column passes everything through.
   task automatic test_degenerate_sizes();
      set_frame_size(0, 0);
      send_pixel();
      send_pixel();
      send_drain();
      send_drain();
      read_bin($urandom_range(0, 4));
      set_frame_size(1, 2);
      repeat (2) send_pixel();
      send_drain();
   endtask

   // Oversized width register, clipped to the line buffer depth; no idling here.
   task automatic test_widest_rows();
      set_frame_size(16'hFFFF, 3);
      steady = 1'b1;
      repeat (3 * LINE_DEPTH) send_pixel();
      repeat (LINE_DEPTH) send_drain();
      for (int i = 0; i < HIST_BINS; i++) read_bin(i);
      steady = 1'b0;
   endtask

   // Tallest frame: a few rows in, then a drain that must be ignored.
   task automatic test_tall_frame();
      set_frame_size(6, 16'hFFFF);
      repeat (24) send_pixel();
      send_drain();
      for (int i = 0; i < HIST_BINS; i++) read_bin(i);
   endtask

   // Mostly whole frames of random size and content, with noise and cut frames.
   task automatic test_random_frames(input int unsigned target);
      int unsigned first;
      int unsigned w;
      int unsigned h;
      int unsigned n;
      bit          cut;
      first = items_sent;
      w     = 0;
      h     = 0;
      while (items_sent - first < target) begin
         if (w == 0 || $urandom_range(9) < 7) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = $urandom_range(1, 8);
            set_frame_size(w, h);
         end else begin
            send_item(CMD_START, random_pixel(), BIN_BITS'($urandom));
         end
         cut = ($urandom_range(9) == 0);
         n   = cut ? $urandom_range(0, w * h) : w * h;
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(99) < 4) begin
               case ($urandom_range(9))
                  0: send_item(CMD_START, random_pixel(), BIN_BITS'($urandom));
                  1, 2, 3: send_drain();
                  default: read_bin($urandom_range(0, 7));
               endcase
            end
            send_pixel();
         end
         if (!cut) begin
            if ($urandom_range(4) == 0) wait_drained();
            repeat (w) send_drain();
            if ($urandom_range(2) == 0) send_drain();
         end
         repeat ($urandom_range(1, 3)) read_bin($urandom_range(0, 7));
      end
   endtask

   initial begin
      foreach (bin_tally[i]) bin_tally[i] = '0;
      foreach (line_above[i]) begin
         line_above[i]  = '0;
         line_middle[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_kernel_3x3();
      test_degenerate_sizes();
      test_widest_rows();
      test_tall_frame();
      test_random_frames(RANDOM_ITEMS);
      wait_drained();
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
